/* rtl/tdtss_pkg.sv */
// Shared constants, codes and types of the timeout state sequencer.
package tdtss_pkg;

	localparam int STATE_COUNT = 16;
	localparam int STATE_W     = 8;
	localparam int TIME_W      = 32;
	localparam int ENTRY_W     = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int ADDR_W      = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
	localparam int CNT_W       = $clog2(TIME_W);

	localparam logic [STATE_W-1:0] STATE_NONE        = '0;
	localparam logic [STATE_W-1:0] START_STATE_RESET = STATE_W'(1);
	localparam logic [STATE_W-1:0] HOLD_CODE_RESET   = '1;

	typedef enum logic {
		OP_STEP  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HOLD_CODE   = 1'b0,
		REG_START_STATE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_NEXT,
		S_LOAD,
		S_DIV,
		S_ADD,
		S_FINISH
	} seq_state_t;

endpackage

/* rtl/table_driven_timeout_state_sequencer.sv */
// Table-driven timeout state sequencer: descriptor memory, control sequencer and serial remainder.
//
// One item is taken at a time. A descriptor write goes from its transfer straight to the S_FINISH
// state. A step that only holds or does nothing passes S_DECIDE; a step that enters a state with
// a fixed timeout also passes S_LOAD, and S_NEXT before it when the entry comes from timer expiry
// (the successor is read from the descriptor memory first). A step that enters a state with a
// random timeout then passes S_DIV and S_ADD: the remainder of the random word by the timeout span
// is formed one bit per cycle, and this loop sets the rate. A new item is taken as soon as the
// previous result has gone to the output register, even if that result is still waiting. The
// descriptor memory is not cleared; an entry must be written before its state is entered.
// After reset the block is in state 1 with no timer running.
module table_driven_timeout_state_sequencer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Item channel.
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  op,
	input  logic [tdtss_pkg::TIME_W-1:0]          now,
	input  logic [tdtss_pkg::STATE_W-1:0]         requested_state,
	input  logic [tdtss_pkg::TIME_W-1:0]          random_word,
	input  logic [tdtss_pkg::ENTRY_W-1:0]         entry_index,
	input  logic [tdtss_pkg::TIME_W-1:0]          entry_timeout_min,
	input  logic [tdtss_pkg::TIME_W-1:0]          entry_timeout_max,
	input  logic [tdtss_pkg::STATE_W-1:0]         entry_timeout_next,
	// Result channel.
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [tdtss_pkg::STATE_W-1:0]         current_state,
	output logic                                  entered,
	output logic                                  by_timeout,
	output logic [tdtss_pkg::TIME_W-1:0]          timeout_loaded,
	// Configuration write channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tdtss_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tdtss_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tdtss_pkg::*;

	seq_state_t state_q, state_d;

	logic [STATE_W-1:0] hold_q, present_q, req_q, target_q, out_state_q;
	logic [TIME_W-1:0]  timeout_q, start_q, now_q, rnd_q, lo_q, span_q, rem_q, tv_new_q;
	logic [TIME_W-1:0]  out_tv_q;
	logic               enter_q, by_to_q, tgt_oob_q;
	logic               out_valid_q, out_entered_q, out_by_to_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [TIME_W-1:0]  min_mem [STATE_COUNT];
	logic [TIME_W-1:0]  max_mem [STATE_COUNT];
	logic [STATE_W-1:0] next_mem [STATE_COUNT];
	logic [TIME_W-1:0]  rd_min_q, rd_max_q;
	logic [STATE_W-1:0] rd_next_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;

	logic               in_acc, out_free, wr_ok;
	logic               do_enter, do_hold, expired, pres_oob, trivial;
	logic [TIME_W-1:0]  elapsed, desc_min, desc_max;
	logic [STATE_W-1:0] desc_next, next_tgt;
	logic [TIME_W:0]    trial;
	logic               trial_ge;

	function automatic logic beyond_table(input logic [STATE_W-1:0] s);
		return 32'(s) >= STATE_COUNT;
	endfunction

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign wr_ok     = 32'(entry_index) < STATE_COUNT;

	assign do_enter = (req_q != STATE_NONE) && (req_q != hold_q);
	assign do_hold  = (req_q != STATE_NONE) && (req_q == hold_q);
	assign elapsed  = now_q - start_q;
	assign expired  = (req_q == STATE_NONE) && (timeout_q != '0) && (elapsed > timeout_q);
	assign pres_oob = beyond_table(present_q);
	assign next_tgt = pres_oob ? STATE_NONE : rd_next_q;

	// A state beyond the table behaves as an all-zero descriptor.
	assign desc_min  = tgt_oob_q ? '0 : rd_min_q;
	assign desc_max  = tgt_oob_q ? '0 : rd_max_q;
	assign desc_next = tgt_oob_q ? STATE_NONE : rd_next_q;
	assign trivial   = (desc_max == '0) || (desc_next == STATE_NONE) || (desc_max == desc_min);

	// One restoring remainder step: shift in the next dividend bit, subtract if it fits.
	assign trial    = {rem_q, rnd_q[TIME_W-1]};
	assign trial_ge = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(present_q);
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (op == OP_WRITE) ? S_FINISH : S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (do_enter) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(req_q);
					state_d = S_LOAD;
				end else if (expired) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(present_q);
					state_d = S_NEXT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(next_tgt);
				state_d = S_LOAD;
			end
			S_LOAD: begin
				state_d = trivial ? S_FINISH : S_DIV;
			end
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Architectural state and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= HOLD_CODE_RESET;
			present_q   <= START_STATE_RESET;
			timeout_q   <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The start register only matters at reset, which restores its default, so a
			// write to it is accepted and has no lasting effect.
			if (cfg_valid && cfg_ready && (cfg_index == REG_HOLD_CODE)) begin
				hold_q <= cfg_data;
			end
			if ((state_q == S_DECIDE) && do_hold && (timeout_q != '0)) begin
				start_q <= now_q;
			end
			if ((state_q == S_FINISH) && out_free && enter_q) begin
				present_q <= target_q;
				timeout_q <= tv_new_q;
				start_q   <= now_q;
			end
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					now_q   <= now;
					req_q   <= requested_state;
					rnd_q   <= random_word;
					enter_q <= 1'b0;
					by_to_q <= 1'b0;
				end
			end
			S_DECIDE: begin
				if (do_enter) begin
					target_q  <= req_q;
					tgt_oob_q <= beyond_table(req_q);
					enter_q   <= 1'b1;
				end else if (expired) begin
					enter_q <= 1'b1;
					by_to_q <= 1'b1;
				end
			end
			S_NEXT: begin
				target_q  <= next_tgt;
				tgt_oob_q <= beyond_table(next_tgt);
			end
			S_LOAD: begin
				lo_q     <= desc_min;
				span_q   <= desc_max - desc_min;
				rem_q    <= '0;
				cnt_q    <= CNT_W'(TIME_W - 1);
				tv_new_q <= ((desc_max == '0) || (desc_next == STATE_NONE)) ? '0 : desc_max;
			end
			S_DIV: begin
				rem_q <= trial_ge ? TIME_W'(trial - {1'b0, span_q}) : trial[TIME_W-1:0];
				rnd_q <= {rnd_q[TIME_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			S_ADD: begin
				tv_new_q <= lo_q + rem_q;
			end
			S_FINISH: begin
				if (out_free) begin
					out_state_q   <= enter_q ? target_q : present_q;
					out_tv_q      <= enter_q ? tv_new_q : timeout_q;
					out_entered_q <= enter_q;
					out_by_to_q   <= by_to_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Descriptor memory: written on a write transfer, read one entry per request.
	always_ff @(posedge clk) begin
		if (in_acc && (op == OP_WRITE) && wr_ok) begin
			min_mem[ADDR_W'(entry_index)]  <= entry_timeout_min;
			max_mem[ADDR_W'(entry_index)]  <= entry_timeout_max;
			next_mem[ADDR_W'(entry_index)] <= entry_timeout_next;
		end
		if (rd_en) begin
			rd_min_q  <= min_mem[rd_addr];
			rd_max_q  <= max_mem[rd_addr];
			rd_next_q <= next_mem[rd_addr];
		end
	end

	assign out_valid      = out_valid_q;
	assign current_state  = out_state_q;
	assign entered        = out_entered_q;
	assign by_timeout     = out_by_to_q;
	assign timeout_loaded = out_tv_q;

	// The partial remainder always stays below the span.
	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < span_q))
		else $error("remainder not below span");

	// An entry by timer expiry is always reported as an entry.
	a_timeout_is_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_by_to_q || out_entered_q))
		else $error("timeout flag without entry");

	// A descriptor write goes straight to the result and never enters a state.
	a_write_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op == OP_WRITE)) |=> ((state_q == S_FINISH) && !enter_q))
		else $error("descriptor write took the step path");

	// The successor lookup only happens while a timer runs.
	a_next_needs_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NEXT) |-> (timeout_q != '0) && by_to_q)
		else $error("successor lookup without a running timer");

endmodule

/* sim/table_driven_timeout_state_sequencer_tb.sv */
// Self-checking testbench for the table-driven timeout state sequencer.
module table_driven_timeout_state_sequencer_tb;
	import tdtss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int RANDOM_PER_PHASE = 375;

	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  now;
		logic [STATE_W-1:0] req;
		logic [TIME_W-1:0]  rnd;
		logic [ENTRY_W-1:0] idx;
		logic [TIME_W-1:0]  tmin;
		logic [TIME_W-1:0]  tmax;
		logic [STATE_W-1:0] tnext;
	} seq_item_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic               entered;
		logic               by_timeout;
		logic [TIME_W-1:0]  timeout;
	} seq_result_t;

	// Tracks the sequencer state and the results it owes, in transfer order.
	class sequencer_scoreboard;
		logic [STATE_W-1:0] hold_code;
		// The start register only matters at reset, which this run does not repeat.
		logic [STATE_W-1:0] start_reg;
		logic [STATE_W-1:0] state_now;
		logic [TIME_W-1:0]  timeout_now;
		logic [TIME_W-1:0]  timer_origin;
		logic [TIME_W-1:0]  desc_min [STATE_COUNT];
		logic [TIME_W-1:0]  desc_max [STATE_COUNT];
		logic [STATE_W-1:0] desc_next [STATE_COUNT];
		seq_result_t        owed_results [$];
		int                 errors;

		function new();
			hold_code    = HOLD_CODE_RESET;
			start_reg    = START_STATE_RESET;
			state_now    = START_STATE_RESET;
			timeout_now  = '0;
			timer_origin = '0;
			errors       = 0;
			for (int i = 0; i < STATE_COUNT; i++) begin
				desc_min[i]  = '0;
				desc_max[i]  = '0;
				desc_next[i] = '0;
			end
		endfunction

		function void set_register(cfg_reg_t index, logic [CFG_DATA_W-1:0] data);
			if (index == REG_HOLD_CODE) begin
				hold_code = data;
			end else begin
				start_reg = data;
			end
		endfunction

		function void enter_state(logic [STATE_W-1:0] target, logic [TIME_W-1:0] now,
				logic [TIME_W-1:0] rnd);
			logic [TIME_W-1:0]  lo;
			logic [TIME_W-1:0]  hi;
			logic [TIME_W-1:0]  span;
			logic [STATE_W-1:0] nx;
			lo = '0;
			hi = '0;
			nx = '0;
			state_now = target;
			if (target < STATE_COUNT) begin
				lo = desc_min[target];
				hi = desc_max[target];
				nx = desc_next[target];
			end
			span = hi - lo;
			if (hi == 0 || nx == 0) begin
				timeout_now = '0;
			end else if (span == 0) begin
				timeout_now = hi;
			end else begin
				timeout_now = lo + rnd % span;
			end
			timer_origin = now;
		endfunction

		function void note_item(seq_item_t it);
			seq_result_t        res;
			logic [TIME_W-1:0]  elapsed;
			logic [STATE_W-1:0] successor;
			res.entered    = 1'b0;
			res.by_timeout = 1'b0;
			elapsed = it.now - timer_origin;
			if (it.op == OP_WRITE) begin
				desc_min[it.idx]  = it.tmin;
				desc_max[it.idx]  = it.tmax;
				desc_next[it.idx] = it.tnext;
			end else if (it.req != STATE_NONE) begin
				if (it.req == hold_code) begin
					if (timeout_now != 0) timer_origin = it.now;
				end else begin
					enter_state(it.req, it.now, it.rnd);
					res.entered = 1'b1;
				end
			end else if (timeout_now != 0 && elapsed > timeout_now) begin
				successor = (state_now < STATE_COUNT) ? desc_next[state_now] : STATE_NONE;
				enter_state(successor, it.now, it.rnd);
				res.entered    = 1'b1;
				res.by_timeout = 1'b1;
			end
			res.state   = state_now;
			res.timeout = timeout_now;
			owed_results.push_back(res);
		endfunction

		function void check_result(logic [STATE_W-1:0] state, logic ent, logic by_to,
				logic [TIME_W-1:0] timeout);
			seq_result_t exp_res;
			if (owed_results.size() == 0) begin
				$error("result transfer with nothing expected: state %0d", state);
				errors++;
				return;
			end
			exp_res = owed_results.pop_front();
			if (state !== exp_res.state) begin
				$error("current_state expected %0d got %0d", exp_res.state, state);
				errors++;
			end
			if (ent !== exp_res.entered) begin
				$error("entered expected %0d got %0d", exp_res.entered, ent);
				errors++;
			end
			if (by_to !== exp_res.by_timeout) begin
				$error("by_timeout expected %0d got %0d", exp_res.by_timeout, by_to);
				errors++;
			end
			if (timeout !== exp_res.timeout) begin
				$error("timeout_loaded expected %0d got %0d", exp_res.timeout, timeout);
				errors++;
			end
		endfunction

		function int pending();
			return owed_results.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   op;
	logic [TIME_W-1:0]      now;
	logic [STATE_W-1:0]     requested_state;
	logic [TIME_W-1:0]      random_word;
	logic [ENTRY_W-1:0]     entry_index;
	logic [TIME_W-1:0]      entry_timeout_min;
	logic [TIME_W-1:0]      entry_timeout_max;
	logic [STATE_W-1:0]     entry_timeout_next;
	logic                   out_valid;
	logic                   out_stall;
	logic [STATE_W-1:0]     current_state;
	logic                   entered;
	logic                   by_timeout;
	logic [TIME_W-1:0]      timeout_loaded;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	sequencer_scoreboard board;
	logic [TIME_W-1:0]   wall;
	bit                  no_idle;
	int                  press_req;

	table_driven_timeout_state_sequencer DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.op                 (op),
		.now                (now),
		.requested_state    (requested_state),
		.random_word        (random_word),
		.entry_index        (entry_index),
		.entry_timeout_min  (entry_timeout_min),
		.entry_timeout_max  (entry_timeout_max),
		.entry_timeout_next (entry_timeout_next),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.current_state      (current_state),
		.entered            (entered),
		.by_timeout         (by_timeout),
		.timeout_loaded     (timeout_loaded),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic seq_item_t step_item(logic [TIME_W-1:0] t, logic [STATE_W-1:0] req,
			logic [TIME_W-1:0] rnd);
		seq_item_t it;
		it.op    = OP_STEP;
		it.now   = t;
		it.req   = req;
		it.rnd   = rnd;
		it.idx   = '0;
		it.tmin  = '0;
		it.tmax  = '0;
		it.tnext = '0;
		return it;
	endfunction

	function automatic seq_item_t write_item(logic [ENTRY_W-1:0] idx, logic [TIME_W-1:0] tmin,
			logic [TIME_W-1:0] tmax, logic [STATE_W-1:0] tnext);
		seq_item_t it;
		it       = step_item($urandom(), STATE_W'($urandom_range(0, 255)), $urandom());
		it.op    = OP_WRITE;
		it.idx   = idx;
		it.tmin  = tmin;
		it.tmax  = tmax;
		it.tnext = tnext;
		return it;
	endfunction

	// Mostly a steadily advancing clock with small timeouts, so that timers expire often.
	function automatic seq_item_t random_item();
		seq_item_t it;
		int        roll;
		int        pick;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0) begin
			wall = $urandom();
		end else begin
			wall = wall + $urandom_range(0, 30);
		end
		it = step_item(wall, STATE_W'($urandom_range(0, 255)), $urandom());
		it.idx   = ENTRY_W'($urandom_range(0, STATE_COUNT - 1));
		it.tmin  = $urandom();
		it.tmax  = $urandom();
		it.tnext = STATE_W'($urandom_range(0, 255));
		if (roll < 8) begin
			it.op = OP_WRITE;
			pick  = $urandom_range(0, 9);
			case (pick)
				0: it.tmax = '0;
				1: it.tnext = STATE_NONE;
				2: begin
					it.tmin = $urandom_range(0, 40);
					it.tmax = it.tmin;
				end
				3: begin
					it.tmax = $urandom_range(0, 40);
					it.tmin = it.tmax + $urandom_range(1, 40);
				end
				4: ;
				default: begin
					it.tmin = $urandom_range(0, 20);
					it.tmax = it.tmin + $urandom_range(1, 60);
				end
			endcase
			if (pick != 1 && pick != 4 && $urandom_range(0, 3) != 0)
				it.tnext = STATE_W'($urandom_range(1, STATE_COUNT - 1));
		end else if (roll < 16) begin
			it.req = STATE_W'($urandom_range(1, STATE_COUNT - 1));
		end else if (roll < 20) begin
			// Keep the fully random request, which may reach past the table.
		end else if (roll < 27) begin
			it.req = board.hold_code;
		end else begin
			it.req = STATE_NONE;
		end
		return it;
	endfunction

	task automatic push_item(seq_item_t it, bit last);
		in_valid           <= 1'b1;
		op                 <= it.op;
		now                <= it.now;
		requested_state    <= it.req;
		random_word        <= it.rnd;
		entry_index        <= it.idx;
		entry_timeout_min  <= it.tmin;
		entry_timeout_max  <= it.tmax;
		entry_timeout_next <= it.tnext;
		do @(posedge clk); while (in_stall);
		board.note_item(it);
		if (last || (!no_idle && $urandom_range(0, 99) < 6)) begin
			in_valid <= 1'b0;
			if (!last) repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic write_registers(logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] start);
		cfg_valid <= 1'b1;
		cfg_index <= REG_HOLD_CODE;
		cfg_data  <= hold;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(REG_HOLD_CODE, hold);
		cfg_index <= REG_START_STATE;
		cfg_data  <= start;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(REG_START_STATE, start);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: checks every transfer and throttles with random and long stalls.
	initial begin : result_sink
		int hold_left;
		int press_seen;
		hold_left  = 0;
		press_seen = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				board.check_result(current_state, entered, by_timeout, timeout_loaded);
			if (press_req != press_seen) begin
				press_seen = press_req;
				hold_left  = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(0, 99) < 6);
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles == STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] hold_set [4];
		logic [CFG_DATA_W-1:0] start_set [4];
		hold_set  = '{8'd255, 8'd0, 8'h5A, 8'd1};
		start_set = '{8'd0, 8'd255, 8'h80, 8'd1};
		board              = new();
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		op                 = OP_STEP;
		now                = '0;
		requested_state    = '0;
		random_word        = '0;
		entry_index        = '0;
		entry_timeout_min  = '0;
		entry_timeout_max  = '0;
		entry_timeout_next = '0;
		cfg_valid          = 1'b0;
		cfg_index          = REG_HOLD_CODE;
		cfg_data           = '0;
		no_idle            = 1'b0;
		press_req          = 0;
		wall               = 32'hFFFF_F000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 4; p++) begin
			drain();
			write_registers(hold_set[p], start_set[p]);
			if (p == 0) begin
				// Every descriptor is loaded before any state can be entered.
				push_item(write_item(0, 0, 0, 0), 1'b0);
				push_item(write_item(1, 5, 5, 2), 1'b0);
				push_item(write_item(2, 3, 10, 3), 1'b0);
				push_item(write_item(3, 10, 4, 1), 1'b0);
				push_item(write_item(4, 0, '1, 8'd255), 1'b0);
				push_item(write_item(5, '1, '1, 1), 1'b0);
				push_item(write_item(6, 2, 8, 0), 1'b0);
				for (int i = 7; i < STATE_COUNT; i++)
					push_item(write_item(ENTRY_W'(i), 1, 20, STATE_W'((i % 15) + 1)), 1'b0);
				// Hold and idle tick with no timer, then fixed and random timeouts.
				push_item(step_item(0, STATE_NONE, 0), 1'b0);
				push_item(step_item(50, 8'd255, '1), 1'b0);
				push_item(step_item(100, 1, 0), 1'b0);
				push_item(step_item(105, STATE_NONE, 0), 1'b0);
				push_item(step_item(106, STATE_NONE, 32'hDEAD_BEEF), 1'b0);
				push_item(step_item(110, 8'd255, 0), 1'b0);
				push_item(step_item(111, 8'd200, '1), 1'b0);
				push_item(step_item(32'hFFFF_FFF0, 4, '1), 1'b0);
				push_item(step_item(5, 3, 32'h8000_0001), 1'b0);
				push_item(step_item(32'h7FFF_FFFF, STATE_NONE, '1), 1'b1);
			end
			if (p == 2) no_idle = 1'b1;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (p == 1 && n == 100) press_req <= press_req + 1;
				if (p == 2 && n == 200) no_idle = 1'b0;
				push_item(random_item(), n == RANDOM_PER_PHASE - 1);
			end
		end
		drain();
		if (board.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/tdtss_pkg.sv
rtl/table_driven_timeout_state_sequencer.sv
sim/table_driven_timeout_state_sequencer_tb.sv
